// ===== hw/rtl/gv_pkg.sv =====
// ----------------------------------------------------------------------------
// gv_pkg: shared types and constants for the pairwise geometry check
// Holds the rotation step table, fixed datapath widths and register indexes.
// ----------------------------------------------------------------------------
package gv_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int N_CELLS         = 30;
    localparam int XY_W            = 45;
    localparam int Z_W             = 32;
    localparam int NORM_W          = 41;
    localparam int KSQ_W           = 33;
    localparam int MINLEN_W        = 17;
    localparam int MNSQ_W          = 2 * MINLEN_W;
    localparam int CFG_W           = 17;
    localparam int CFG_IDX_W       = 2;
    localparam int FRONT_STAGES    = 7;
    localparam int LATENCY         = FRONT_STAGES + N_CELLS + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH_CHANGE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE_CHANGE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TRAIN_LENGTH  = 2'd2;

    localparam logic [Z_W-1:0] Z_HALF_TURN = 32'h8000_0000;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam logic [Z_W-1:0] ATAN_TURNS [N_CELLS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic        [Z_W-1:0]  z;
    } t_rot;

endpackage

// ===== hw/rtl/gv_cell.sv =====
// ----------------------------------------------------------------------------
// gv_cell: one vectoring step for the training and the test vector
// Rotates both vectors toward the x axis by a fixed step and accumulates angle.
// ----------------------------------------------------------------------------
module gv_cell #(
    parameter int STEP = 0
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic         i_ok,
    input  gv_pkg::t_rot i_t,
    input  gv_pkg::t_rot i_s,
    output logic         o_valid,
    output logic         o_ok,
    output gv_pkg::t_rot o_t,
    output gv_pkg::t_rot o_s
);
    import gv_pkg::*;

    logic r_valid;
    logic r_ok;
    t_rot r_t, r_s;
    t_rot n_t, n_s;

    function automatic t_rot rot_step(input t_rot v);
        t_rot r;
        logic signed [XY_W-1:0] xs;
        logic signed [XY_W-1:0] ys;
        xs = v.x >>> STEP;
        ys = v.y >>> STEP;
        if (!v.y[XY_W-1]) begin
            r.x = v.x + ys;
            r.y = v.y - xs;
            r.z = v.z + ATAN_TURNS[STEP];
        end else begin
            r.x = v.x - ys;
            r.y = v.y + xs;
            r.z = v.z - ATAN_TURNS[STEP];
        end
        return r;
    endfunction

    always_comb begin
        n_t = rot_step(i_t);
        n_s = rot_step(i_s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_ok <= i_ok;
        r_t  <= n_t;
        r_s  <= n_s;
    end

    assign o_valid = r_valid;
    assign o_ok    = r_ok;
    assign o_t     = r_t;
    assign o_s     = r_s;

endmodule

// ===== hw/rtl/gv_front.sv =====
// ----------------------------------------------------------------------------
// gv_front: offset vectors, length tests and normalization
// Forms both offsets, checks the length ratio and minimum length, and scales
// each vector so that its larger magnitude sits at bit 40.
// ----------------------------------------------------------------------------
module gv_front #(
    parameter int W = gv_pkg::COORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic signed [W-1:0]         i_train_a_x,
    input  logic signed [W-1:0]         i_train_a_y,
    input  logic signed [W-1:0]         i_train_b_x,
    input  logic signed [W-1:0]         i_train_b_y,
    input  logic signed [W-1:0]         i_test_a_x,
    input  logic signed [W-1:0]         i_test_a_y,
    input  logic signed [W-1:0]         i_test_b_x,
    input  logic signed [W-1:0]         i_test_b_y,
    input  logic [gv_pkg::KSQ_W-1:0]    i_ksq,
    input  logic [gv_pkg::MNSQ_W-1:0]   i_mnsq,
    output logic                        o_valid,
    output logic                        o_ok,
    output gv_pkg::t_rot                o_t,
    output gv_pkg::t_rot                o_s
);
    import gv_pkg::*;

    localparam int LW  = 2 * W + 1;
    localparam int CW  = (LW > MNSQ_W) ? LW : MNSQ_W;
    localparam int NCH = (LW + 31) / 32;
    localparam int PW  = NCH * 32;
    localparam int PPW = 32 + KSQ_W;
    localparam int RW  = PW + KSQ_W;

    typedef struct packed {
        logic              neg;
        logic              yneg;
        logic [NORM_W-1:0] m;
        logic [NORM_W-1:0] ax;
        logic [NORM_W-1:0] ay;
    } t_nrm;

    function automatic t_nrm prep(input logic signed [W:0] x, input logic signed [W:0] y);
        t_nrm r;
        logic signed [W:0] xn;
        logic signed [W:0] yn;
        logic signed [W:0] ya;
        r.neg = x[W];
        xn    = r.neg ? -x : x;
        yn    = r.neg ? -y : y;
        r.yneg = yn[W];
        ya    = r.yneg ? -yn : yn;
        r.ax  = NORM_W'(xn[W-1:0]);
        r.ay  = NORM_W'(ya[W-1:0]);
        r.m   = (r.ax > r.ay) ? r.ax : r.ay;
        return r;
    endfunction

    function automatic t_nrm norm_step(input t_nrm v, input int s);
        t_nrm r;
        r = v;
        if ((v.m >> (NORM_W - s)) == '0) begin
            r.m  = v.m << s;
            r.ax = v.ax << s;
            r.ay = v.ay << s;
        end
        return r;
    endfunction

    function automatic t_rot to_rot(input t_nrm v);
        t_rot r;
        logic signed [XY_W-1:0] ay;
        ay  = $signed(XY_W'(v.ay));
        r.x = $signed(XY_W'(v.ax));
        r.y = v.yneg ? -ay : ay;
        r.z = v.neg ? Z_HALF_TURN : '0;
        return r;
    endfunction

    // Stage 1: offsets.
    logic              r1_valid;
    logic signed [W:0] r1_tx, r1_ty, r1_sx, r1_sy;
    // Stage 2: folded magnitudes.
    logic r2_valid;
    t_nrm r2_t, r2_s;
    // Stage 3: squares, first normalization steps.
    logic          r3_valid;
    logic [2*W-1:0] r3_tsx, r3_tsy, r3_ssx, r3_ssy;
    t_nrm          r3_t, r3_s;
    // Stage 4: squared lengths, last normalization steps.
    logic          r4_valid;
    logic [LW-1:0] r4_lt, r4_ls;
    logic          r4_nz;
    t_nrm          r4_t, r4_s;
    // Stage 5: longer and shorter length, minimum length test.
    logic          r5_valid, r5_ok;
    logic [LW-1:0] r5_lng, r5_sht;
    t_rot          r5_t, r5_s;
    // Stage 6: partial products of the scaled shorter length.
    logic           r6_valid, r6_ok;
    logic [PPW-1:0] r6_pp [NCH];
    logic [RW-1:0]  r6_lhs;
    t_rot           r6_t, r6_s;
    // Stage 7: ratio test.
    logic r7_valid, r7_ok;
    t_rot r7_t, r7_s;

    logic [PW-1:0] sht_p;
    logic [RW-1:0] rhs;

    always_comb begin
        sht_p = PW'(r5_sht);
        rhs   = '0;
        for (int c = 0; c < NCH; c++) begin
            rhs = rhs + (RW'(r6_pp[c]) << (32 * c));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
            r6_valid <= 1'b0;
            r7_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
        end

        r1_tx <= $signed({i_train_a_x[W-1], i_train_a_x}) - $signed({i_train_b_x[W-1], i_train_b_x});
        r1_ty <= $signed({i_train_a_y[W-1], i_train_a_y}) - $signed({i_train_b_y[W-1], i_train_b_y});
        r1_sx <= $signed({i_test_a_x[W-1], i_test_a_x}) - $signed({i_test_b_x[W-1], i_test_b_x});
        r1_sy <= $signed({i_test_a_y[W-1], i_test_a_y}) - $signed({i_test_b_y[W-1], i_test_b_y});

        r2_t <= prep(r1_tx, r1_ty);
        r2_s <= prep(r1_sx, r1_sy);

        r3_tsx <= r2_t.ax[W-1:0] * r2_t.ax[W-1:0];
        r3_tsy <= r2_t.ay[W-1:0] * r2_t.ay[W-1:0];
        r3_ssx <= r2_s.ax[W-1:0] * r2_s.ax[W-1:0];
        r3_ssy <= r2_s.ay[W-1:0] * r2_s.ay[W-1:0];
        r3_t   <= norm_step(norm_step(norm_step(r2_t, 32), 16), 8);
        r3_s   <= norm_step(norm_step(norm_step(r2_s, 32), 16), 8);

        r4_lt <= LW'(r3_tsx) + LW'(r3_tsy);
        r4_ls <= LW'(r3_ssx) + LW'(r3_ssy);
        r4_nz <= (r3_tsx != '0 || r3_tsy != '0) && (r3_ssx != '0 || r3_ssy != '0);
        r4_t  <= norm_step(norm_step(norm_step(r3_t, 4), 2), 1);
        r4_s  <= norm_step(norm_step(norm_step(r3_s, 4), 2), 1);

        r5_lng <= (r4_lt > r4_ls) ? r4_lt : r4_ls;
        r5_sht <= (r4_lt > r4_ls) ? r4_ls : r4_lt;
        r5_ok  <= r4_nz && (CW'(r4_lt) > CW'(i_mnsq));
        r5_t   <= to_rot(r4_t);
        r5_s   <= to_rot(r4_s);

        for (int c = 0; c < NCH; c++) begin
            r6_pp[c] <= PPW'(sht_p[c*32 +: 32]) * PPW'(i_ksq);
        end
        r6_lhs <= RW'(r5_lng) << 16;
        r6_ok  <= r5_ok;
        r6_t   <= r5_t;
        r6_s   <= r5_s;

        r7_ok <= r6_ok && (r6_lhs < rhs);
        r7_t  <= r6_t;
        r7_s  <= r6_s;
    end

    assign o_valid = r7_valid;
    assign o_ok    = r7_ok;
    assign o_t     = r7_t;
    assign o_s     = r7_s;

endmodule

// ===== hw/rtl/bigram_geometric_verify.sv =====
// ----------------------------------------------------------------------------
// bigram_geometric_verify: geometric consistency of two matched keypoint pairs
// Length ratio, minimum length and orientation change tests on one request.
// ----------------------------------------------------------------------------
// Pipeline: seven front stages, thirty rotation cells and one output stage lie
// between an accepted request and its o_done strobe.
// Throughput: one request per cycle; o_busy stays low, every cell step is a
// pipeline stage. The receiver cannot stall.
// Reset: synchronous, active low; clears the pipeline and loads the register
// defaults.
module bigram_geometric_verify #(
    parameter int COORD_WIDTH = gv_pkg::COORD_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic signed [COORD_WIDTH-1:0]  i_train_a_x,
    input  logic signed [COORD_WIDTH-1:0]  i_train_a_y,
    input  logic signed [COORD_WIDTH-1:0]  i_train_b_x,
    input  logic signed [COORD_WIDTH-1:0]  i_train_b_y,
    input  logic signed [COORD_WIDTH-1:0]  i_test_a_x,
    input  logic signed [COORD_WIDTH-1:0]  i_test_a_y,
    input  logic signed [COORD_WIDTH-1:0]  i_test_b_x,
    input  logic signed [COORD_WIDTH-1:0]  i_test_b_y,
    input  logic                           i_cfg_we,
    input  logic [gv_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gv_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                           o_done,
    output logic                           o_verified
);
    import gv_pkg::*;

    // Register values are kept in the form the datapath consumes.
    logic [KSQ_W-1:0]  r_ksq;
    logic [MNSQ_W-1:0] r_mnsq;
    logic [15:0]       r_max_angle;
    logic [16:0]       n_k;

    assign n_k = 17'(i_cfg_data[15:0]) + 17'd256;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksq       <= KSQ_W'(384 * 384);
            r_mnsq      <= '0;
            r_max_angle <= 16'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_LENGTH_CHANGE: r_ksq <= KSQ_W'(n_k * n_k);
                CFG_MAX_ANGLE_CHANGE:  r_max_angle <= i_cfg_data[15:0];
                CFG_MIN_TRAIN_LENGTH:  r_mnsq <= i_cfg_data[16:0] * i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic c_valid [N_CELLS+1];
    logic c_ok    [N_CELLS+1];
    t_rot c_t     [N_CELLS+1];
    t_rot c_s     [N_CELLS+1];

    gv_front #(.W(COORD_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_start && !o_busy),
        .i_train_a_x (i_train_a_x),
        .i_train_a_y (i_train_a_y),
        .i_train_b_x (i_train_b_x),
        .i_train_b_y (i_train_b_y),
        .i_test_a_x  (i_test_a_x),
        .i_test_a_y  (i_test_a_y),
        .i_test_b_x  (i_test_b_x),
        .i_test_b_y  (i_test_b_y),
        .i_ksq       (r_ksq),
        .i_mnsq      (r_mnsq),
        .o_valid     (c_valid[0]),
        .o_ok        (c_ok[0]),
        .o_t         (c_t[0]),
        .o_s         (c_s[0])
    );

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        gv_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .i_ok    (c_ok[g]),
            .i_t     (c_t[g]),
            .i_s     (c_s[g]),
            .o_valid (c_valid[g+1]),
            .o_ok    (c_ok[g+1]),
            .o_t     (c_t[g+1]),
            .o_s     (c_s[g+1])
        );
    end

    // The wrapped difference is folded to the smaller of the two directions.
    logic [Z_W-1:0] d_raw, d_fold;
    logic           ang_ok;

    always_comb begin
        d_raw  = c_t[N_CELLS].z - c_s[N_CELLS].z;
        d_fold = (d_raw > Z_HALF_TURN) ? (Z_W'(0) - d_raw) : d_raw;
        ang_ok = d_fold < {r_max_angle, 16'd0};
    end

    logic r_done, r_verified;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done     <= 1'b0;
            r_verified <= 1'b0;
        end else begin
            r_done     <= c_valid[N_CELLS];
            r_verified <= c_valid[N_CELLS] && c_ok[N_CELLS] && ang_ok;
        end
    end

    assign o_done     = r_done;
    assign o_verified = r_verified;

`ifndef NO_ASSERTIONS
    a_done_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, LATENCY))
        else $error("result strobe without a matching request");
    a_verified_in_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_verified |-> o_done)
        else $error("verified set outside a result cycle");
    a_front_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_valid[N_CELLS] && !c_ok[N_CELLS]) |=> (o_done && !o_verified))
        else $error("length rejection lost in the rotation chain");
`endif

endmodule
